// File: sv/dbh_pkg.sv
// shared types and constants for the button debounce, hold and stuck qualifier
// no dependencies
package dbh_pkg;

    localparam int BUTTONS_DEF   = 4;
    localparam int BTN_W         = 2;
    localparam int TIME_W        = 32;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOCKOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_DELAY   = 2'd3;

    localparam logic [CFG_W-1:0] PRESS_LOCKOUT_RST = 16'd50;
    localparam logic [CFG_W-1:0] RELEASE_DELAY_RST = 16'd75;
    localparam logic [CFG_W-1:0] HOLD_DELAY_RST    = 16'd75;
    localparam logic [CFG_W-1:0] STUCK_DELAY_RST   = 16'd2000;

    typedef struct packed {
        logic [TIME_W-1:0] mark;
        logic              stuck;
        logic              hold;
        logic              toggle;
        logic              latched;
    } t_entry;

    typedef struct packed {
        logic [CFG_W-1:0] press_lockout;
        logic [CFG_W-1:0] release_delay;
        logic [CFG_W-1:0] hold_delay;
        logic [CFG_W-1:0] stuck_delay;
    } t_cfg;

    typedef struct packed {
        logic press_event;
        logic toggle;
        logic latched;
        logic hold;
        logic stuck;
    } t_result;

endpackage

// File: sv/dbh_state_mem.sv
// per-button state memory, registered read, valid bits for reset
// depends on dbh_pkg
module dbh_state_mem #(
    parameter int DEPTH = dbh_pkg::BUTTONS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output dbh_pkg::t_entry  o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  dbh_pkg::t_entry  i_wr_data
);

    dbh_pkg::t_entry r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    dbh_pkg::t_entry r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: sv/dbh_update.sv
// press, release, hold and stuck rules applied to one state entry
// depends on dbh_pkg
module dbh_update (
    input  logic                          i_in_range,
    input  logic                          i_pressed,
    input  logic [dbh_pkg::TIME_W-1:0]    i_now_ms,
    input  dbh_pkg::t_entry               i_entry,
    input  dbh_pkg::t_cfg                 i_cfg,
    output dbh_pkg::t_entry               o_entry,
    output dbh_pkg::t_result              o_result
);

    logic [dbh_pkg::TIME_W-1:0] elapsed;
    logic press_hit, release_hit, hold_hit, stuck_hit;

    assign elapsed = i_now_ms - i_entry.mark;

    always_comb begin
        press_hit   = i_pressed && !i_entry.latched
                      && (elapsed > {16'd0, i_cfg.press_lockout});
        release_hit = !i_pressed && i_entry.latched
                      && (elapsed > {16'd0, i_cfg.release_delay});
        hold_hit    = i_pressed && i_entry.latched
                      && (elapsed > {16'd0, i_cfg.hold_delay})
                      && (elapsed <= {16'd0, i_cfg.stuck_delay});
        stuck_hit   = i_pressed && i_entry.latched
                      && (elapsed > {16'd0, i_cfg.stuck_delay});

        o_entry        = i_entry;
        o_entry.toggle = i_entry.toggle ^ press_hit ^ hold_hit ^ stuck_hit;
        if (press_hit || release_hit) begin
            o_entry.mark = i_now_ms;
        end
        if (press_hit) begin
            o_entry.latched = 1'b1;
        end else if (release_hit) begin
            o_entry.latched = 1'b0;
            o_entry.hold    = 1'b0;
            o_entry.stuck   = 1'b0;
        end else if (stuck_hit) begin
            o_entry.hold    = 1'b0;
            o_entry.stuck   = 1'b1;
        end else if (hold_hit) begin
            o_entry.hold    = 1'b1;
        end

        if (i_in_range) begin
            o_result.press_event = press_hit;
            o_result.toggle      = o_entry.toggle;
            o_result.latched     = o_entry.latched;
            o_result.hold        = o_entry.hold;
            o_result.stuck       = o_entry.stuck;
        end else begin
            o_result = '0;
        end
    end

endmodule

// File: sv/button_debounce_hold_stuck_top.sv
// top level of the button qualifier: config registers, read stage, update, output register
// depends on dbh_pkg, dbh_state_mem, dbh_update
//
//   channel  direction  beat contents                           handshake
//   poll     in         i_button, i_pressed, i_now_ms           i_valid / o_stall
//   result   out        o_press_event, o_toggle, o_latched,     o_valid / i_stall
//                       o_hold, o_stuck
//
// one poll per cycle sustained while i_stall is low; results leave from the output register
// the read stage reads the button's entry from memory, then the update applies the rules and writes back
// a write to the entry read in the same cycle is forwarded to the next poll
// reset clears the per-button valid bits at once, so entries read as zero until written
// the read stage holds under output stall, and o_stall rises only when it cannot move on
module button_debounce_hold_stuck_top #(
    parameter int BUTTONS = dbh_pkg::BUTTONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [dbh_pkg::BTN_W-1:0]        i_button,
    input  logic                             i_pressed,
    input  logic [dbh_pkg::TIME_W-1:0]       i_now_ms,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_press_event,
    output logic                             o_toggle,
    output logic                             o_latched,
    output logic                             o_hold,
    output logic                             o_stuck,
    input  logic                             i_cfg_wr_en,
    input  logic [dbh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dbh_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int AW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int XW = AW + dbh_pkg::BTN_W + 1;

    dbh_pkg::t_cfg r_cfg;

    logic                          r_s1_valid;
    logic [AW-1:0]                 r_s1_addr;
    logic                          r_s1_in_range;
    logic                          r_s1_pressed;
    logic [dbh_pkg::TIME_W-1:0]    r_s1_now;
    logic                          r_fwd_hit;
    dbh_pkg::t_entry               r_fwd_data;
    logic                          r_out_valid;
    dbh_pkg::t_result              r_out;

    logic [XW-1:0]    btn_ext;
    logic [AW-1:0]    in_addr;
    logic             in_range;
    logic             in_acc;
    logic             s1_go;
    dbh_pkg::t_entry  rd_entry;
    dbh_pkg::t_entry  cur_entry;
    dbh_pkg::t_entry  new_entry;
    dbh_pkg::t_result new_result;

    assign btn_ext  = XW'(i_button);
    assign in_addr  = btn_ext[AW-1:0];
    assign in_range = (btn_ext < XW'(BUTTONS));

    assign s1_go   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_go;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_lockout <= dbh_pkg::PRESS_LOCKOUT_RST;
            r_cfg.release_delay <= dbh_pkg::RELEASE_DELAY_RST;
            r_cfg.hold_delay    <= dbh_pkg::HOLD_DELAY_RST;
            r_cfg.stuck_delay   <= dbh_pkg::STUCK_DELAY_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dbh_pkg::CFG_PRESS_LOCKOUT: r_cfg.press_lockout <= i_cfg_data;
                dbh_pkg::CFG_RELEASE_DELAY: r_cfg.release_delay <= i_cfg_data;
                dbh_pkg::CFG_HOLD_DELAY:    r_cfg.hold_delay    <= i_cfg_data;
                dbh_pkg::CFG_STUCK_DELAY:   r_cfg.stuck_delay   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dbh_state_mem #(
        .DEPTH (BUTTONS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_entry),
        .i_wr_en   (s1_go && r_s1_in_range),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (new_entry)
    );

    assign cur_entry = r_fwd_hit ? r_fwd_data : rd_entry;

    dbh_update u_update (
        .i_in_range (r_s1_in_range),
        .i_pressed  (r_s1_pressed),
        .i_now_ms   (r_s1_now),
        .i_entry    (cur_entry),
        .i_cfg      (r_cfg),
        .o_entry    (new_entry),
        .o_result   (new_result)
    );

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_fwd_hit  <= s1_go && r_s1_in_range && in_range && (r_s1_addr == in_addr);
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr     <= in_addr;
            r_s1_in_range <= in_range;
            r_s1_pressed  <= i_pressed;
            r_s1_now      <= i_now_ms;
            r_fwd_data    <= new_entry;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= new_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_press_event = r_out.press_event;
    assign o_toggle      = r_out.toggle;
    assign o_latched     = r_out.latched;
    assign o_hold        = r_out.hold;
    assign o_stuck       = r_out.stuck;

endmodule

// File: sv/dbh_checker.sv
// port-level checks for the button qualifier, bound to the top level
// depends on button_debounce_hold_stuck_top
module dbh_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic o_press_event,
    input logic o_toggle,
    input logic o_latched,
    input logic o_hold,
    input logic o_stuck
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped under stall");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_press_event, o_toggle, o_latched, o_hold, o_stuck}))
        else $error("result beat changed under stall");

    a_unlatched_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_latched |-> !o_hold && !o_stuck)
        else $error("hold or stuck on an unlatched button");

    a_press_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_press_event |-> o_latched && !o_hold && !o_stuck)
        else $error("press beat without a fresh latch");

endmodule

bind button_debounce_hold_stuck_top dbh_checker u_dbh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_press_event (o_press_event),
    .o_toggle      (o_toggle),
    .o_latched     (o_latched),
    .o_hold        (o_hold),
    .o_stuck       (o_stuck)
);

// File: tb/tb_button_debounce_hold_stuck_top.sv
// testbench for button_debounce_hold_stuck_top: directed polls, then press/hold/release runs
// with random timing under several register settings, every result beat checked by a predictor
// depends on dbh_pkg and button_debounce_hold_stuck_top
module tb_button_debounce_hold_stuck_top;
    import dbh_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    class button_flag_checker;
        logic [CFG_W-1:0]  lockout_ms;
        logic [CFG_W-1:0]  release_ms;
        logic [CFG_W-1:0]  hold_ms;
        logic [CFG_W-1:0]  stuck_ms;
        logic              latched_q [BUTTONS_DEF];
        logic              toggle_q  [BUTTONS_DEF];
        logic              hold_q    [BUTTONS_DEF];
        logic              stuck_q   [BUTTONS_DEF];
        logic [TIME_W-1:0] mark_q    [BUTTONS_DEF];
        t_result           expected_flags [$];
        int                errors;

        function new();
            lockout_ms = PRESS_LOCKOUT_RST;
            release_ms = RELEASE_DELAY_RST;
            hold_ms    = HOLD_DELAY_RST;
            stuck_ms   = STUCK_DELAY_RST;
            for (int i = 0; i < BUTTONS_DEF; i++) begin
                latched_q[i] = 1'b0;
                toggle_q[i]  = 1'b0;
                hold_q[i]    = 1'b0;
                stuck_q[i]   = 1'b0;
                mark_q[i]    = '0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_PRESS_LOCKOUT: lockout_ms = val;
                CFG_RELEASE_DELAY: release_ms = val;
                CFG_HOLD_DELAY:    hold_ms    = val;
                CFG_STUCK_DELAY:   stuck_ms   = val;
                default: ;
            endcase
        endfunction

        function void take_poll(logic [BTN_W-1:0] btn, logic closed, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] elapsed;
            t_result           r;
            r = '0;
            elapsed = now - mark_q[btn];
            if (closed && !latched_q[btn] && elapsed > lockout_ms) begin
                toggle_q[btn]  = !toggle_q[btn];
                latched_q[btn] = 1'b1;
                mark_q[btn]    = now;
                r.press_event  = 1'b1;
            end
            elapsed = now - mark_q[btn];
            if (!closed && latched_q[btn] && elapsed > release_ms) begin
                latched_q[btn] = 1'b0;
                hold_q[btn]    = 1'b0;
                stuck_q[btn]   = 1'b0;
                mark_q[btn]    = now;
            end
            elapsed = now - mark_q[btn];
            if (closed && latched_q[btn] && elapsed > hold_ms && elapsed <= stuck_ms) begin
                hold_q[btn]   = 1'b1;
                toggle_q[btn] = !toggle_q[btn];
            end
            if (closed && latched_q[btn] && elapsed > stuck_ms) begin
                hold_q[btn]   = 1'b0;
                stuck_q[btn]  = 1'b1;
                toggle_q[btn] = !toggle_q[btn];
            end
            r.toggle  = toggle_q[btn];
            r.latched = latched_q[btn];
            r.hold    = hold_q[btn];
            r.stuck   = stuck_q[btn];
            expected_flags.push_back(r);
        endfunction

        function void compare_bit(string field, logic want, logic got);
            if (got !== want) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: %s expected %0b got %0b", $time, field, want, got);
            end
        endfunction

        function void check_flags(t_result got);
            t_result want;
            if (expected_flags.size() == 0) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: result beat with no poll outstanding, expected none got %b",
                             $time, got);
                return;
            end
            want = expected_flags.pop_front();
            compare_bit("press_event", want.press_event, got.press_event);
            compare_bit("toggle", want.toggle, got.toggle);
            compare_bit("latched", want.latched, got.latched);
            compare_bit("hold", want.hold, got.hold);
            compare_bit("stuck", want.stuck, got.stuck);
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [BTN_W-1:0]   i_button = '0;
    logic               i_pressed = 1'b0;
    logic [TIME_W-1:0]  i_now_ms = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_press_event;
    logic               o_toggle;
    logic               o_latched;
    logic               o_hold;
    logic               o_stuck;
    logic               i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    button_flag_checker flags;
    logic               calm = 1'b0;
    bit                 gaps_on = 1'b1;
    int                 polls_sent = 0;
    int                 stall_run = 0;
    int                 quiet_cycles = 0;
    logic [TIME_W-1:0]  btn_time [BUTTONS_DEF];

    button_debounce_hold_stuck_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_button      (i_button),
        .i_pressed     (i_pressed),
        .i_now_ms      (i_now_ms),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_press_event (o_press_event),
        .o_toggle      (o_toggle),
        .o_latched     (o_latched),
        .o_hold        (o_hold),
        .o_stuck       (o_stuck),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // output stall in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            stall_run = 0;
            i_stall <= 1'b0;
        end else begin
            if (stall_run == 0 && $urandom_range(0, 7) == 0)
                stall_run = $urandom_range(1, 18);
            if (stall_run > 0) begin
                i_stall <= 1'b1;
                stall_run--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // beat monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                flags.take_poll(i_button, i_pressed, i_now_ms);
            if (o_valid && !i_stall)
                flags.check_flags(t_result'({o_press_event, o_toggle, o_latched, o_hold,
                                             o_stuck}));
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("tb_button_debounce_hold_stuck_top: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_poll(input logic [BTN_W-1:0] btn, input logic closed,
                             input logic [TIME_W-1:0] now);
        int gap;
        if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_button  <= btn;
        i_pressed <= closed;
        i_now_ms  <= now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        polls_sent++;
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (flags.pending() != 0);
    endtask

    task automatic load_cfg(input logic [CFG_W-1:0] lockout, input logic [CFG_W-1:0] rel,
                            input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] stuck);
        wait_results();
        repeat (3) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_PRESS_LOCKOUT;
        i_cfg_data  <= lockout;
        @(posedge i_clk);
        i_cfg_index <= CFG_RELEASE_DELAY;
        i_cfg_data  <= rel;
        @(posedge i_clk);
        i_cfg_index <= CFG_HOLD_DELAY;
        i_cfg_data  <= hold;
        @(posedge i_clk);
        i_cfg_index <= CFG_STUCK_DELAY;
        i_cfg_data  <= stuck;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        flags.set_reg(CFG_PRESS_LOCKOUT, lockout);
        flags.set_reg(CFG_RELEASE_DELAY, rel);
        flags.set_reg(CFG_HOLD_DELAY, hold);
        flags.set_reg(CFG_STUCK_DELAY, stuck);
    endtask

    task automatic noise_poll();
        logic [BTN_W-1:0]  btn;
        logic [TIME_W-1:0] now;
        btn = BTN_W'($urandom_range(0, BUTTONS_DEF - 1));
        if ($urandom_range(0, 3) == 0)
            now = $urandom();
        else
            now = btn_time[btn] + $urandom_range(0, flags.stuck_ms + 100);
        send_poll(btn, 1'($urandom_range(0, 1)), now);
    endtask

    // press on the lockout edge, hold polls around the hold and stuck edges, then release
    task automatic press_cycle(input logic [BTN_W-1:0] btn);
        logic [TIME_W-1:0] t_press;
        logic [TIME_W-1:0] off;
        logic [TIME_W-1:0] rel_off;
        logic [TIME_W-1:0] offs [$];
        t_press = btn_time[btn] + flags.lockout_ms + 32'd1;
        if ($urandom_range(0, 1))
            send_poll(btn, 1'b1, t_press - 32'd1);
        send_poll(btn, 1'b1, t_press);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 4))
                0: off = TIME_W'(flags.hold_ms);
                1: off = flags.hold_ms + 32'd1;
                2: off = TIME_W'(flags.stuck_ms);
                3: off = flags.stuck_ms + 32'd1;
                default: off = $urandom_range(0, flags.stuck_ms + 20);
            endcase
            offs.push_back(off);
        end
        offs.sort();
        foreach (offs[k]) begin
            if ($urandom_range(0, 9) == 0)
                send_poll(btn, 1'b0, t_press + $urandom_range(0, flags.release_ms));
            send_poll(btn, 1'b1, t_press + offs[k]);
            if ($urandom_range(0, 7) == 0)
                noise_poll();
        end
        rel_off = TIME_W'(flags.release_ms);
        if (offs.size() != 0 && offs[$] > rel_off)
            rel_off = offs[$];
        send_poll(btn, 1'b0, t_press + rel_off);
        send_poll(btn, 1'b0, t_press + rel_off + 32'd1);
        btn_time[btn] = t_press + rel_off + 32'd1;
    endtask

    task automatic run_phase(input int count, input logic [TIME_W-1:0] base);
        int stop;
        stop = polls_sent + count;
        for (int i = 0; i < BUTTONS_DEF; i++)
            btn_time[i] = base + 32'(i) * 32'd7;
        while (polls_sent < stop) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 4)) noise_poll();
                end
                default: begin
                    press_cycle(BTN_W'($urandom_range(0, BUTTONS_DEF - 1)));
                end
            endcase
            if (!calm && $urandom_range(0, 39) == 0)
                wait_results();
        end
    endtask

    initial begin
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] rl;
        logic [CFG_W-1:0] hd;
        logic [CFG_W-1:0] sd;
        flags = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: lockout, hold and stuck edges, bounce, release
        send_poll(2'd0, 1'b1, 32'd0);
        send_poll(2'd0, 1'b1, 32'd50);
        send_poll(2'd0, 1'b1, 32'd51);
        send_poll(2'd0, 1'b1, 32'd126);
        send_poll(2'd0, 1'b1, 32'd127);
        send_poll(2'd0, 1'b0, 32'd126);
        send_poll(2'd0, 1'b1, 32'd2051);
        send_poll(2'd0, 1'b1, 32'd2052);
        send_poll(2'd0, 1'b0, 32'd2053);
        send_poll(2'd0, 1'b0, 32'd2054);
        send_poll(2'd0, 1'b1, 32'd2103);
        // timestamp wrap
        send_poll(2'd1, 1'b1, 32'hFFFF_FFFF);
        send_poll(2'd1, 1'b1, 32'h0000_004B);
        send_poll(2'd1, 1'b0, 32'h0000_004C);
        send_poll(2'd2, 1'b0, 32'hAAAA_AAAA);
        send_poll(2'd2, 1'b1, 32'h5555_5555);
        send_poll(2'd2, 1'b1, 32'h5555_5555 + 32'd3000);
        // time going backwards reads as a huge elapsed time
        send_poll(2'd3, 1'b1, 32'h8000_0000);
        send_poll(2'd3, 1'b0, 32'h8000_0000);
        send_poll(2'd3, 1'b1, 32'h7FFF_FFFF);
        send_poll(2'd3, 1'b0, 32'h8000_004C);

        load_cfg('0, '0, '0, '0);
        run_phase(210, $urandom());
        load_cfg('1, '1, '1, '1);
        run_phase(180, $urandom());
        load_cfg(16'd7, 16'd3, 16'd40, 16'd40);
        run_phase(200, $urandom());
        load_cfg(16'd12, 16'd9, 16'd300, 16'd100);
        run_phase(200, $urandom());
        repeat (3) begin
            lo = CFG_W'($urandom_range(0, 100));
            rl = CFG_W'($urandom_range(0, 100));
            hd = CFG_W'($urandom_range(0, 150));
            sd = hd + CFG_W'($urandom_range(0, 300));
            load_cfg(lo, rl, hd, sd);
            run_phase(200, $urandom());
        end
        load_cfg(PRESS_LOCKOUT_RST, RELEASE_DELAY_RST, HOLD_DELAY_RST, STUCK_DELAY_RST);
        calm = 1'b1;
        run_phase(250, 32'hFFFF_F000);

        wait_results();
        repeat (8) @(posedge i_clk);
        if (flags.errors == 0 && flags.pending() == 0)
            $display("tb_button_debounce_hold_stuck_top: done, clean");
        else
            $display("tb_button_debounce_hold_stuck_top: done, errors");
        $finish;
    end
endmodule

// File: files.f
sv/dbh_pkg.sv
sv/dbh_state_mem.sv
sv/dbh_update.sv
sv/button_debounce_hold_stuck_top.sv
sv/dbh_checker.sv
tb/tb_button_debounce_hold_stuck_top.sv
